FILE: rtl/core/bhc_pkg.sv
// ----------------------------------------------------------------------------
// BMP header checker package
// Shared types, status codes and header byte positions.
// ----------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_SIG   = 3'd1,
        STATUS_SHORT_HDR = 3'd2,
        STATUS_COMPRESSED = 3'd3,
        STATUS_NOT_24BIT = 3'd4
    } status_t;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] POS_SIG_END    = 6'd1;
    localparam logic [POS_W-1:0] POS_OFFSET_END = 6'd13;
    localparam logic [POS_W-1:0] POS_INFO_END   = 6'd17;
    localparam logic [POS_W-1:0] POS_WIDTH_END  = 6'd21;
    localparam logic [POS_W-1:0] POS_HEIGHT_END = 6'd25;
    localparam logic [POS_W-1:0] POS_DEPTH_END  = 6'd29;
    localparam logic [POS_W-1:0] POS_COMP_END   = 6'd33;
    localparam logic [POS_W-1:0] POS_LAST       = 6'd53;
    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;

    localparam logic [15:0] SIGNATURE_BM  = 16'h4D42;
    localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
    localparam logic [15:0] WANTED_DEPTH  = 16'd24;

    typedef struct packed {
        logic       valid;
        logic [7:0] header_byte;
        logic       start_of_file;
    } byte_item_t;

    // (4 - width*3 mod 4) mod 4 reduces to width mod 4
    function automatic logic [1:0] row_pad(input logic [31:0] width);
        logic [1:0] pad;
        pad = 2'd0;
        if (!width[31] && (width != 32'd0))
        begin
            pad = width[1:0];
        end
        return pad;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bhc_in_if.sv
// ----------------------------------------------------------------------------
// BMP header checker byte channel
// Valid/ready channel carrying one file byte and its start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       start_of_file;

    modport source (output valid, output header_byte, output start_of_file, input ready);
    modport sink   (input valid, input header_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bhc_out_if.sv
// ----------------------------------------------------------------------------
// BMP header checker verdict channel
// Valid/ready channel carrying one verdict per file.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [31:0]        pixel_data_offset;
    logic signed [31:0] image_width;
    logic signed [31:0] image_height;
    logic [1:0]         row_padding;

    modport source (output valid, output status, output pixel_data_offset,
                    output image_width, output image_height, output row_padding,
                    input ready);
    modport sink   (input valid, input status, input pixel_data_offset,
                    input image_width, input image_height, input row_padding,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bmp_header_checker_core.sv
// ----------------------------------------------------------------------------
// BMP header checker core
// Parses a BMP file header from a byte stream and reports one verdict per file.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while no verdict waits on the result
// channel, with start_of_file marking the first byte of each file. A byte
// passes through an input register and then the parser, whose field
// registers update once per byte; the verdict a byte decides (byte 1 for a
// bad signature, byte 17 for a short info header, otherwise byte 53) goes
// into the result register that drives the result channel. While a verdict
// waits there the parser holds, and the byte channel stalls as soon as the
// input register is full. Files cut short or restarted mid-header give no
// verdict; bytes after a verdict are dropped until the next start.
`default_nettype none

module bmp_header_checker_core (
    input  wire logic clk,
    input  wire logic rst_n,
    bhc_in_if.sink    bytes,
    bhc_out_if.source verdicts
);

    bhc_pkg::byte_item_t item;
    logic                advance;

    bhc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .item    (item)
    );

    bhc_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .advance  (advance),
        .verdicts (verdicts)
    );

endmodule

`default_nettype wire

FILE: rtl/core/bhc_in_stage.sv
// ----------------------------------------------------------------------------
// BMP header checker input register
// Captures one byte request per cycle ahead of the parser, while empty or advancing.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    bhc_in_if.sink                bytes,
    input  wire logic             advance,
    output bhc_pkg::byte_item_t   item
);

    logic                 valid_reg;
    logic [7:0]           byte_reg;
    logic                 sof_reg;
    logic                 load;

    assign load        = !valid_reg || advance;
    assign bytes.ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && bytes.valid)
        begin
            byte_reg <= bytes.header_byte;
            sof_reg  <= bytes.start_of_file;
        end
    end

    always_comb
    begin
        item.valid         = valid_reg;
        item.header_byte   = byte_reg;
        item.start_of_file = sof_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/bhc_parser.sv
// ----------------------------------------------------------------------------
// BMP header checker parser
// Assembles header fields, decides the verdict and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  bhc_pkg::byte_item_t   item,
    output logic                  advance,
    bhc_out_if.source             verdicts
);

    logic [bhc_pkg::POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [31:0]               fa_reg, fa_next, fa_cur;
    logic [31:0]               offset_reg, offset_next;
    logic [31:0]               width_reg, width_next;
    logic [31:0]               height_reg, height_next;
    logic [15:0]               depth_reg, depth_next;
    logic                      comp_reg, comp_next;
    logic                      done_reg, done_next;

    logic                      emit;
    bhc_pkg::status_t          status_next;
    logic                      ok_next;

    logic                      res_valid_reg;
    logic [2:0]                res_status_reg;
    logic [31:0]               res_offset_reg;
    logic [31:0]               res_width_reg;
    logic [31:0]               res_height_reg;
    logic [1:0]                res_pad_reg;

    assign advance = !res_valid_reg || verdicts.ready;

    always_comb
    begin
        pos_cur     = item.start_of_file ? '0 : pos_reg;
        fa_cur      = item.start_of_file ? '0 : fa_reg;
        offset_next = item.start_of_file ? '0 : offset_reg;
        width_next  = item.start_of_file ? '0 : width_reg;
        height_next = item.start_of_file ? '0 : height_reg;
        depth_next  = item.start_of_file ? '0 : depth_reg;
        comp_next   = item.start_of_file ? 1'b0 : comp_reg;
        done_next   = item.start_of_file ? 1'b0 : done_reg;
        fa_next     = fa_cur;
        pos_next    = pos_cur;
        emit        = 1'b0;
        status_next = bhc_pkg::STATUS_OK;
        ok_next     = 1'b0;

        if (!done_next)
        begin
            fa_next = {item.header_byte, fa_cur[31:8]};
            if (pos_cur != bhc_pkg::POS_MAX)
            begin
                pos_next = pos_cur + 1'b1;
            end
            case (pos_cur)
                bhc_pkg::POS_SIG_END:
                begin
                    if (fa_next[31:16] != bhc_pkg::SIGNATURE_BM)
                    begin
                        emit        = 1'b1;
                        status_next = bhc_pkg::STATUS_BAD_SIG;
                    end
                end
                bhc_pkg::POS_OFFSET_END: offset_next = fa_next;
                bhc_pkg::POS_INFO_END:
                begin
                    if (fa_next < bhc_pkg::MIN_INFO_SIZE)
                    begin
                        emit        = 1'b1;
                        status_next = bhc_pkg::STATUS_SHORT_HDR;
                    end
                end
                bhc_pkg::POS_WIDTH_END:  width_next  = fa_next;
                bhc_pkg::POS_HEIGHT_END: height_next = fa_next;
                bhc_pkg::POS_DEPTH_END:  depth_next  = fa_next[31:16];
                bhc_pkg::POS_COMP_END:   comp_next   = (fa_next != 32'd0);
                bhc_pkg::POS_LAST:
                begin
                    emit = 1'b1;
                    if (comp_next)
                    begin
                        status_next = bhc_pkg::STATUS_COMPRESSED;
                    end
                    else if (depth_next != bhc_pkg::WANTED_DEPTH)
                    begin
                        status_next = bhc_pkg::STATUS_NOT_24BIT;
                    end
                    else
                    begin
                        status_next = bhc_pkg::STATUS_OK;
                        ok_next     = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (emit)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fa_reg        <= '0;
            offset_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            depth_reg     <= '0;
            comp_reg      <= 1'b0;
            done_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item.valid && emit;
            if (item.valid)
            begin
                pos_reg    <= pos_next;
                fa_reg     <= fa_next;
                offset_reg <= offset_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                depth_reg  <= depth_next;
                comp_reg   <= comp_next;
                done_reg   <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.valid && emit)
        begin
            res_status_reg <= status_next;
            res_offset_reg <= ok_next ? offset_next : 32'd0;
            res_width_reg  <= ok_next ? width_next : 32'd0;
            res_height_reg <= ok_next ? height_next : 32'd0;
            res_pad_reg    <= ok_next ? bhc_pkg::row_pad(width_next) : 2'd0;
        end
    end

    assign verdicts.valid             = res_valid_reg;
    assign verdicts.status            = res_status_reg;
    assign verdicts.pixel_data_offset = res_offset_reg;
    assign verdicts.image_width       = res_width_reg;
    assign verdicts.image_height      = res_height_reg;
    assign verdicts.row_padding       = res_pad_reg;

endmodule

`default_nettype wire

FILE: tb/sv/bmp_header_checker_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP header checker core testbench
// Streams BMP headers, well formed and broken, through the byte channel with
// random idling on both sides for most of the run. A byte-level parser inside
// the bench predicts each verdict, and every verdict that comes out is checked against it.
// ----------------------------------------------------------------------------

module bmp_header_checker_core_test;

    localparam int HDR_LEN   = 54;
    localparam int AT_SIG    = 1;
    localparam int AT_OFFSET = 13;
    localparam int AT_INFO   = 17;
    localparam int AT_WIDTH  = 21;
    localparam int AT_HEIGHT = 25;
    localparam int AT_DEPTH  = 29;
    localparam int AT_COMP   = 33;
    localparam int AT_LAST   = 53;
    localparam int AT_MAX    = 63;
    localparam int HOLD_LEN  = 300;

    localparam logic [15:0] SIG_BM   = 16'h4D42;
    localparam logic [31:0] INFO_MIN = 32'd40;
    localparam logic [15:0] DEPTH_24 = 16'd24;

    typedef enum int {
        FILE_OK,
        FILE_BAD_SIG,
        FILE_SHORT_INFO,
        FILE_COMPRESSED,
        FILE_WRONG_DEPTH,
        FILE_CUT
    } file_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } file_byte_t;

    typedef struct packed {
        bhc_pkg::status_t   status;
        logic [31:0]        offset;
        logic signed [31:0] width;
        logic signed [31:0] height;
        logic [1:0]         pad;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bhc_in_if  byte_ch ();
    bhc_out_if verdict_ch ();

    bmp_header_checker_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (byte_ch),
        .verdicts (verdict_ch)
    );

    always #2 clk = ~clk;

    file_byte_t byte_q[$];
    verdict_t   verdict_q[$];

    logic        idle_on = 1'b1;
    int          stall_ticket = 0;
    int          stall_taken = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    int          errors = 0;
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          files_queued = 0;
    int          verdicts_checked = 0;
    int          status_seen[5];

    // parser state
    logic [5:0]  pos;
    logic [31:0] shift_word;
    logic [31:0] offset_r;
    logic [31:0] width_r;
    logic [31:0] height_r;
    logic [15:0] depth_r;
    logic        compressed;
    logic        verdict_done = 1'b1;

    task automatic post_verdict(input bhc_pkg::status_t st);
        verdict_t    v;
        logic [31:0] tripled;
        v = '0;
        v.status = st;
        if (st == bhc_pkg::STATUS_OK)
        begin
            v.offset = offset_r;
            v.width  = width_r;
            v.height = height_r;
            if (!width_r[31] && width_r != 32'd0)
            begin
                tripled = width_r * 32'd3;
                v.pad = 2'd0 - tripled[1:0];
            end
        end
        verdict_q = {verdict_q, v};
        verdict_done = 1'b1;
    endtask

    task automatic parse_header_byte(input logic [7:0] b, input logic sof);
        int at_pos;
        if (sof)
        begin
            pos          = '0;
            shift_word   = '0;
            offset_r     = '0;
            width_r      = '0;
            height_r     = '0;
            depth_r      = '0;
            compressed   = 1'b0;
            verdict_done = 1'b0;
        end
        if (!verdict_done)
        begin
            shift_word = {b, shift_word[31:8]};
            at_pos = int'(pos);
            if (at_pos < AT_MAX)
                pos = pos + 6'd1;
            case (at_pos)
                AT_SIG:
                    if (shift_word[31:16] != SIG_BM)
                        post_verdict(bhc_pkg::STATUS_BAD_SIG);
                AT_OFFSET: offset_r = shift_word;
                AT_INFO:
                    if (shift_word < INFO_MIN)
                        post_verdict(bhc_pkg::STATUS_SHORT_HDR);
                AT_WIDTH:  width_r = shift_word;
                AT_HEIGHT: height_r = shift_word;
                AT_DEPTH:  depth_r = shift_word[31:16];
                AT_COMP:   compressed = (shift_word != 32'd0);
                AT_LAST:
                begin
                    if (compressed)
                        post_verdict(bhc_pkg::STATUS_COMPRESSED);
                    else if (depth_r != DEPTH_24)
                        post_verdict(bhc_pkg::STATUS_NOT_24BIT);
                    else
                        post_verdict(bhc_pkg::STATUS_OK);
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        file_byte_t nxt;
        if (!rst_n)
        begin
            byte_ch.valid         <= 1'b0;
            byte_ch.header_byte   <= '0;
            byte_ch.start_of_file <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_header_byte(byte_ch.header_byte, byte_ch.start_of_file);
                bytes_taken++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_ch.valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 4);
                    byte_ch.valid <= 1'b0;
                end
                else if (byte_q.size() > 0)
                begin
                    nxt = byte_q.pop_front();
                    byte_ch.header_byte   <= nxt.data;
                    byte_ch.start_of_file <= nxt.sof;
                    byte_ch.valid         <= 1'b1;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_verdicts
        verdict_t exp_v;
        if (!rst_n)
        begin
            verdict_ch.ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected verdict: status %0d", verdict_ch.status);
                    errors++;
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    verdicts_checked++;
                    status_seen[exp_v.status]++;
                    if (verdict_ch.status !== exp_v.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_v.status,
                               verdict_ch.status);
                        errors++;
                    end
                    if (verdict_ch.pixel_data_offset !== exp_v.offset)
                    begin
                        $error("pixel_data_offset: expected %h, got %h", exp_v.offset,
                               verdict_ch.pixel_data_offset);
                        errors++;
                    end
                    if (verdict_ch.image_width !== exp_v.width)
                    begin
                        $error("image_width: expected %h, got %h", exp_v.width,
                               verdict_ch.image_width);
                        errors++;
                    end
                    if (verdict_ch.image_height !== exp_v.height)
                    begin
                        $error("image_height: expected %h, got %h", exp_v.height,
                               verdict_ch.image_height);
                        errors++;
                    end
                    if (verdict_ch.row_padding !== exp_v.pad)
                    begin
                        $error("row_padding: expected %0d, got %0d", exp_v.pad,
                               verdict_ch.row_padding);
                        errors++;
                    end
                end
            end
            if (stall_ticket != stall_taken)
            begin
                stall_taken = stall_ticket;
                hold_left = HOLD_LEN;
                verdict_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                verdict_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                verdict_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 4);
                verdict_ch.ready <= 1'b0;
            end
            else
            begin
                verdict_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd3;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic sof);
        byte_q = {byte_q, file_byte_t'{data: data, sof: sof}};
        bytes_queued++;
    endtask

    task automatic queue_file(input file_kind_t kind);
        logic [HDR_LEN*8-1:0] hdr;
        logic [15:0]          sig;
        logic [15:0]          depth;
        logic [31:0]          info;
        logic [31:0]          comp;
        int                   len;
        int                   extra;
        for (int i = 0; i < HDR_LEN; i++)
            hdr[i*8 +: 8] = 8'($urandom);
        sig   = SIG_BM;
        depth = DEPTH_24;
        comp  = '0;
        case ($urandom_range(0, 2))
            0: info = INFO_MIN;
            1: info = 32'hFFFF_FFFF;
            default: info = $urandom_range(40, 255);
        endcase
        len   = HDR_LEN;
        extra = $urandom_range(0, 4);
        case (kind)
            FILE_BAD_SIG:
            begin
                case ($urandom_range(0, 3))
                    0: sig = 16'h424D;
                    1: sig = 16'h4D43;
                    2: sig = 16'hCD42;
                    default: sig = 16'($urandom);
                endcase
                if (sig == SIG_BM)
                    sig = ~sig;
                len = 2;
            end
            FILE_SHORT_INFO:
            begin
                case ($urandom_range(0, 2))
                    0: info = 32'd0;
                    1: info = INFO_MIN - 32'd1;
                    default: info = $urandom_range(0, 39);
                endcase
                len = AT_INFO + 1;
            end
            FILE_COMPRESSED:
            begin
                comp = pick_word();
                if (comp == 32'd0)
                    comp = 32'd1 << $urandom_range(0, 31);
            end
            FILE_WRONG_DEPTH:
            begin
                case ($urandom_range(0, 3))
                    0: depth = 16'h0118;
                    1: depth = 16'hFFFF;
                    2: depth = 16'd32;
                    default: depth = 16'($urandom);
                endcase
                if (depth == DEPTH_24)
                    depth = 16'd8;
            end
            FILE_CUT:
            begin
                len = $urandom_range(1, HDR_LEN - 1);
                extra = 0;
            end
            default: ;
        endcase
        hdr[0*8 +: 16]         = sig;
        hdr[10*8 +: 32]        = pick_word();
        hdr[14*8 +: 32]        = info;
        hdr[18*8 +: 32]        = pick_word();
        hdr[22*8 +: 32]        = pick_word();
        hdr[28*8 +: 16]        = depth;
        hdr[30*8 +: 32]        = comp;
        for (int i = 0; i < len; i++)
            push_byte(hdr[i*8 +: 8], i == 0);
        for (int i = 0; i < extra; i++)
            push_byte(8'($urandom), 1'b0);
        files_queued++;
    endtask

    task automatic run_files(input int byte_goal);
        int r;
        while (bytes_queued < byte_goal)
        begin
            if (files_queued < 12)
            begin
                queue_file(file_kind_t'(files_queued % 6));
            end
            else
            begin
                r = $urandom_range(0, 9);
                case (r)
                    0, 1, 2, 3: queue_file(FILE_OK);
                    4: queue_file(FILE_BAD_SIG);
                    5: queue_file(FILE_SHORT_INFO);
                    6: queue_file(FILE_COMPRESSED);
                    7: queue_file(FILE_WRONG_DEPTH);
                    default: queue_file(FILE_CUT);
                endcase
            end
        end
    endtask

    task automatic wait_sent();
        while (byte_q.size() != 0 || byte_ch.valid)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (verdict_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray bytes before any start, a "BM" among them
        push_byte(8'h42, 1'b0);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h00, 1'b0);
        // wrong second byte, then a trailing byte to drop
        push_byte(8'h42, 1'b1);
        push_byte(8'h58, 1'b0);
        push_byte(8'hFF, 1'b0);
        // bytes swapped
        push_byte(8'h4D, 1'b1);
        push_byte(8'h42, 1'b0);
        // good signature, restarted mid-header
        push_byte(8'h42, 1'b1);
        push_byte(8'h4D, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h42, 1'b1);
        push_byte(8'h42, 1'b1);
        push_byte(8'h4D, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b0);

        run_files(700);
        wait_sent();
        stall_ticket = stall_ticket + 1;
        run_files(1000);
        wait_drained();
        run_files(1550);
        wait_sent();
        idle_on = 1'b0;
        run_files(1850);
        wait_drained();
        repeat (12) @(posedge clk);

        $display("Sent %0d bytes in %0d files, %0d verdicts checked.",
                 bytes_taken, files_queued, verdicts_checked);
        $display("Verdicts by status (ok/sig/info/comp/depth): %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
